### design/quicksort_engine_assert.svh
// assertion macros shared by the quicksort engine modules
// depends on nothing; included inside module bodies
`ifndef QUICKSORT_ENGINE_ASSERT_SVH
`define QUICKSORT_ENGINE_ASSERT_SVH

// implication checked every clock, quiet during reset
`define QS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define QS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/qs_pkg.sv
// shared types and constants for the quicksort engine
// depends on nothing
`default_nettype none
package qs_pkg;
   localparam int MaxItems   = 64;
   localparam int ValueBits  = 32;
   localparam int IdxBits    = $clog2(MaxItems);
   localparam int CntBits    = $clog2(MaxItems + 1);
   localparam int StackDepth = IdxBits + 2;
   localparam int StkBits    = $clog2(StackDepth);
   localparam int SpBits     = $clog2(StackDepth + 1);

   typedef struct packed {
      logic signed [ValueBits-1:0] value;
      logic                        last;
   } req_type;

   typedef struct packed {
      logic signed [ValueBits-1:0] value_res;
      logic                        last_res;
      logic                        dropped;
   } rsp_type;

   // signed compare as unsigned key
   function automatic logic [ValueBits-1:0] key_of(input logic [ValueBits-1:0] v);
      key_of = v ^ {1'b1, {(ValueBits-1){1'b0}}};
   endfunction
endpackage
`default_nettype wire

### design/quicksort_engine.sv
// quicksort engine top level on qs_pkg, qs_ram and quicksort_engine_assert.svh
// load: one transfer per cycle while in S_LOAD; sorts in place
// sort: each range is partitioned around its pivot, and the smaller side is popped first
// output: after the sort ends, results are read from the ram in order, one per cycle unless stalled
// input stalls from the last item until the final result is registered
// reset clears count, drop flag, stack pointer, output valid and the sequencer; ram is not cleared
`default_nettype none
module quicksort_engine (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire qs_pkg::req_type  req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output qs_pkg::rsp_type       rsp_data
);
   import qs_pkg::*;

   // sequencer states
   localparam logic [3:0] S_LOAD = 4'd0,  S_POP    = 4'd1,  S_RDF  = 4'd2,  S_RDM  = 4'd3,
                          S_RDL  = 4'd4,  S_CHOOSE = 4'd5,  S_SW3  = 4'd6,  S_LOR  = 4'd7,
                          S_LOC  = 4'd8,  S_HIC    = 4'd9,  S_XW2  = 4'd10, S_XR2  = 4'd11,
                          S_XW1  = 4'd12, S_PUSH   = 4'd13, S_OUTR = 4'd14, S_OUTD = 4'd15;

   logic [3:0]           state_ff, state_in;
   logic [CntBits-1:0]   count_ff, count_in;
   logic                 drop_ff, drop_in;
   logic [SpBits-1:0]    sp_ff, sp_in;
   // range stack is small (log depth), held in flops, read only at top
   logic [IdxBits-1:0]   stk_s_ff [StackDepth];
   logic [CntBits-1:0]   stk_n_ff [StackDepth];
   logic [IdxBits-1:0]   s_ff, s_in;
   logic [CntBits-1:0]   n_ff, n_in;
   logic [IdxBits-1:0]   lo_ff, lo_in, hi_ff, hi_in;
   logic [ValueBits-1:0] f_ff, f_in, m_ff, m_in, pv_ff, pv_in, t_ff, t_in;
   logic                 push_ok, push1, push2;
   logic [IdxBits-1:0]   ps1, ps2;
   logic [CntBits-1:0]   pn1, pn2;
   logic [StkBits-1:0]   top_idx, wr1_idx, wr2_idx;

   // ram port
   logic                 we;
   logic [IdxBits-1:0]   addr;
   logic [ValueBits-1:0] wdata, rdata;
   logic [IdxBits-1:0]   end_off, mid_off, pa;
   logic [CntBits-1:0]   ln, rn;

   // output register, one entry
   logic                 ovalid_ff, ovalid_in;
   rsp_type              odata_ff, odata_in;
   logic [IdxBits-1:0]   oidx_ff, oidx_in;
   logic                 rsp_held;

   qs_ram #(.Width(ValueBits), .Depth(MaxItems)) u_store (
      .clock (clock), .we (we), .addr (addr), .wdata (wdata), .rdata (rdata)
   );

   assign rsp_valid = ovalid_ff;
   assign rsp_data  = odata_ff;
   assign req_stall = (state_ff != S_LOAD);
   assign rsp_held  = rsp_valid && rsp_stall;

   // offsets inside the current range
   assign end_off = IdxBits'(n_ff - CntBits'(1));
   assign mid_off = IdxBits'(n_ff >> 1);
   // sizes of the two sides around the placed pivot
   assign ln = CntBits'(lo_ff);
   assign rn = CntBits'(n_ff - CntBits'(lo_ff) - CntBits'(1));

   // stack slots: pop from the top, push up to two above it
   assign push1   = (pn1 > CntBits'(1));
   assign push2   = (pn2 > CntBits'(1));
   assign top_idx = StkBits'(sp_ff - SpBits'(1));
   assign wr1_idx = StkBits'(sp_ff);
   assign wr2_idx = StkBits'(sp_ff + SpBits'(push1));

   always_comb begin
      state_in = state_ff; count_in = count_ff; drop_in = drop_ff; sp_in = sp_ff;
      s_in = s_ff; n_in = n_ff; lo_in = lo_ff; hi_in = hi_ff;
      f_in = f_ff; m_in = m_ff; pv_in = pv_ff; t_in = t_ff;
      ovalid_in = ovalid_ff; odata_in = odata_ff; oidx_in = oidx_ff;
      we = 1'b0; addr = '0; wdata = '0; pa = '0;
      push_ok = 1'b0; ps1 = '0; pn1 = '0; ps2 = '0; pn2 = '0;
      // output register frees when its transfer is taken
      if (ovalid_ff && !rsp_stall) begin
         ovalid_in = 1'b0;
      end
      case (state_ff)
         S_LOAD: begin
            if (req_valid) begin
               // store while room is left, else flag the drop
               if (count_ff < CntBits'(MaxItems)) begin
                  we = 1'b1; addr = IdxBits'(count_ff); wdata = req_data.value;
                  count_in = count_ff + CntBits'(1);
               end else begin
                  drop_in = 1'b1;
               end
               if (req_data.last) begin
                  // whole set is the first range; a single element needs no sort
                  s_in = '0; n_in = count_in; oidx_in = '0;
                  state_in = (count_in > CntBits'(1)) ? S_RDF : S_OUTR;
               end
            end
         end
         S_POP: begin
            if (sp_ff == '0) begin
               state_in = S_OUTR;
            end else begin
               sp_in = sp_ff - SpBits'(1);
               s_in = stk_s_ff[top_idx]; n_in = stk_n_ff[top_idx];
               state_in = S_RDF;
            end
         end
         S_RDF: begin
            addr = s_ff; state_in = S_RDM;
         end
         S_RDM: begin
            // rdata holds the first element
            f_in = rdata; addr = s_ff + mid_off; state_in = S_RDL;
         end
         S_RDL: begin
            // rdata holds the middle element
            m_in = rdata; addr = s_ff + end_off; state_in = S_CHOOSE;
         end
         S_CHOOSE: begin
            // rdata holds the last element; middle or first if it lies between the other and the last, else the last
            if (key_of(f_ff) <= key_of(m_ff) && key_of(m_ff) <= key_of(rdata)) begin
               pa = mid_off; pv_in = m_ff;
            end else if (key_of(m_ff) <= key_of(f_ff) && key_of(f_ff) <= key_of(rdata)) begin
               pa = '0; pv_in = f_ff;
            end else begin
               pa = end_off; pv_in = rdata;
            end
            // last element moves to the pivot place
            we = 1'b1; addr = s_ff + pa; wdata = rdata; state_in = S_SW3;
         end
         S_SW3: begin
            // pivot goes to the end of the range
            we = 1'b1; addr = s_ff + end_off; wdata = pv_ff;
            lo_in = '0; hi_in = end_off; state_in = S_LOR;
         end
         S_LOR: begin
            addr = s_ff + lo_ff;
            state_in = (lo_ff < hi_ff) ? S_LOC : S_XR2;
         end
         S_LOC: begin
            // low scan, one element per cycle
            if (lo_ff < end_off && key_of(rdata) <= key_of(pv_ff)) begin
               lo_in = lo_ff + IdxBits'(1); addr = s_ff + lo_in;
            end else begin
               t_in = rdata; addr = s_ff + hi_ff; state_in = S_HIC;
            end
         end
         S_HIC: begin
            // high scan, one element per cycle
            if (hi_ff != '0 && key_of(rdata) >= key_of(pv_ff)) begin
               hi_in = hi_ff - IdxBits'(1); addr = s_ff + hi_in;
            end else if (lo_ff < hi_ff) begin
               we = 1'b1; addr = s_ff + lo_ff; wdata = rdata; state_in = S_XW2;
            end else begin
               state_in = S_LOR;
            end
         end
         S_XW2: begin
            we = 1'b1; addr = s_ff + hi_ff; wdata = t_ff; state_in = S_LOR;
         end
         S_XR2: begin
            // place the pivot where the scans met
            t_in = rdata; we = 1'b1; addr = s_ff + lo_ff; wdata = pv_ff;
            state_in = S_XW1;
         end
         S_XW1: begin
            we = 1'b1; addr = s_ff + end_off; wdata = t_ff; state_in = S_PUSH;
         end
         S_PUSH: begin
            // larger side pushed first, smaller popped first
            if (ln >= rn) begin
               ps1 = s_ff; pn1 = ln; ps2 = s_ff + lo_ff + IdxBits'(1); pn2 = rn;
            end else begin
               ps1 = s_ff + lo_ff + IdxBits'(1); pn1 = rn; ps2 = s_ff; pn2 = ln;
            end
            push_ok = 1'b1;
            sp_in = sp_ff + SpBits'(pn1 > CntBits'(1)) + SpBits'(pn2 > CntBits'(1));
            state_in = S_POP;
         end
         S_OUTR: begin
            addr = oidx_ff; state_in = S_OUTD;
         end
         S_OUTD: begin
            // re-read the same entry while the output register is busy
            addr = oidx_ff;
            if (!ovalid_in) begin
               ovalid_in = 1'b1;
               odata_in.value_res = rdata;
               odata_in.last_res  = (CntBits'(oidx_ff) + CntBits'(1) == count_ff);
               odata_in.dropped   = drop_ff;
               if (odata_in.last_res) begin
                  count_in = '0; drop_in = 1'b0; sp_in = '0; state_in = S_LOAD;
               end else begin
                  oidx_in = oidx_ff + IdxBits'(1); addr = oidx_in;
               end
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD; count_ff <= '0; drop_ff <= 1'b0; sp_ff <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in; count_ff <= count_in; drop_ff <= drop_in; sp_ff <= sp_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff <= s_in; n_ff <= n_in; lo_ff <= lo_in; hi_ff <= hi_in;
      f_ff <= f_in; m_ff <= m_in; pv_ff <= pv_in; t_ff <= t_in;
      odata_ff <= odata_in; oidx_ff <= oidx_in;
      for (int i = 0; i < StackDepth; i++) begin
         if (push_ok && push2 && wr2_idx == StkBits'(i)) begin
            stk_s_ff[i] <= ps2; stk_n_ff[i] <= pn2;
         end else if (push_ok && push1 && wr1_idx == StkBits'(i)) begin
            stk_s_ff[i] <= ps1; stk_n_ff[i] <= pn1;
         end
      end
   end

   `include "quicksort_engine_assert.svh"
   `QS_ASSERT_IMP(a_stall_load, clock, reset, !req_stall, state_ff == S_LOAD, "early accept")
   `QS_ASSERT_IMP(a_count, clock, reset, 1'b1, count_ff <= CntBits'(MaxItems), "count overflow")
   `QS_ASSERT_IMP(a_stack, clock, reset, 1'b1, sp_ff <= SpBits'(StackDepth), "stack overflow")
   `QS_ASSERT_NEXT(a_hold, clock, reset, rsp_held, rsp_valid && $stable(rsp_data), "result moved")
endmodule
`default_nettype wire

### design/qs_ram.sv
// generic single port ram with registered read
// depends on nothing
`default_nettype none
module qs_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(Depth)-1:0] addr,
   input  wire logic [Width-1:0]         wdata,
   output logic      [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire
